// File: hdl/hss_pkg.sv
// Shared constants for the rerouted HyperLogLog spread sketch.
// Used by the divider, the multiplier, the top level and the testbench; depends on nothing.
package hss_pkg;

	// Sketch geometry. REGS and ROWS are powers of two.
	localparam int unsigned ROWS = 1024;
	localparam int unsigned REGS = 32;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int REG_W  = $clog2(REGS);
	localparam int ADDR_W = ROW_W + REG_W;
	localparam int CELLS  = ROWS * REGS;

	// Item and register widths.
	localparam int LBL_W  = 32;
	localparam int CNT_W  = 5;
	localparam int BANK_W = 2 * CNT_W;
	localparam int QW     = 32 - REG_W;
	localparam int MUL_W  = 32;

	// Command codes of an input item.
	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	// Harmonic sum, division and estimate widths.
	localparam int SUM_W  = 33 + REG_W;
	localparam int DVS_W  = SUM_W;
	localparam int DVD_W  = 16 + 32 + 2 * REG_W;
	localparam int DCNT_W = $clog2(DVD_W);
	localparam int EST_W  = DVD_W;
	localparam int LOG_W  = 48;
	localparam int E_W    = 6;
	localparam int MQ_W   = 39;

	// Hash constants.
	localparam logic [31:0] ROW_SEED  = 32'd41213;
	localparam logic [31:0] ELEM_SEED = 32'd12412;
	localparam logic [31:0] MM_C1     = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2     = 32'h1b873593;
	localparam logic [31:0] MM_C3     = 32'h85ebca6b;
	localparam logic [31:0] MM_C4     = 32'hc2b2ae35;
	localparam logic [31:0] MM_ADD    = 32'he6546b64;
	localparam logic [31:0] MM_LEN    = 32'd8;
	localparam logic [31:0] LN2_Q32   = 32'hB17217F8;

	// Bias constant alpha in Q32 and the numerator alpha*REGS^2.
	localparam logic [63:0] ALPHA_DEN = 64'(10 * (1000 * REGS + 1079));
	localparam logic [63:0] ALPHA_Q32 =
		(REGS == 16) ? ((64'd673 << 32) + 64'd500) / 64'd1000 :
		(REGS == 32) ? ((64'd697 << 32) + 64'd500) / 64'd1000 :
		(REGS == 64) ? ((64'd709 << 32) + 64'd500) / 64'd1000 :
		((64'(7213 * REGS) << 32) + ALPHA_DEN / 2) / ALPHA_DEN;
	localparam logic [63:0] NUM_Q32 = ALPHA_Q32 * 64'(REGS) * 64'(REGS);

	// Range limits of the estimate in Q16.
	localparam logic [EST_W-1:0] LIN_LIMIT = EST_W'((5 * REGS) << 15);
	localparam logic [EST_W-1:0] MAX_Q16   = EST_W'(48'hFFFFFFFF0000);

endpackage

// File: hdl/rerouted_hll_spread_sketch_top.sv
// Per-flow spread sketch built on two banks of HyperLogLog registers per row.
// Depends on hss_pkg, hss_ram, hss_mul and hss_div.
//
// After reset the block sweeps its register memory to zero, one entry per cycle,
// over all 32768 entries; in_ready stays low until that pass is over. An update
// (cmd 0) gives no result. A query (cmd 1) gives one spread_estimate: the flow
// is first hashed to its row, then the 32 registers of that row are scanned,
// each with its own hash on the shared multiplier, and each of the two
// estimates then takes a 58-step bit-serial division plus, in the linear or
// large range, a logarithm: up to 47 normalizing shifts, 32 squarings on the
// same multiplier and the final scaling. One item is worked on at a time; a
// finished result waits in an output register while the next item is taken,
// and a query only finishes once the previous result has left that register.
module rerouted_hll_spread_sketch_top import hss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cmd,
	input  logic [LBL_W-1:0] flow_key,
	input  logic [LBL_W-1:0] element_label,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      spread_estimate
);

	typedef enum logic [22:0] {
		ST_CLEAR = 23'h000001,
		ST_IDLE  = 23'h000002,
		ST_K1    = 23'h000004,
		ST_K2    = 23'h000008,
		ST_KS    = 23'h000010,
		ST_H1    = 23'h000020,
		ST_H2    = 23'h000040,
		ST_F1    = 23'h000080,
		ST_F2    = 23'h000100,
		ST_F3    = 23'h000200,
		ST_UPD   = 23'h000400,
		ST_ACC   = 23'h000800,
		ST_DIVS  = 23'h001000,
		ST_DIVW  = 23'h002000,
		ST_CHK   = 23'h004000,
		ST_LNORM = 23'h008000,
		ST_LSQ   = 23'h010000,
		ST_LSQ2  = 23'h020000,
		ST_LM1   = 23'h040000,
		ST_LM2   = 23'h080000,
		ST_LM3   = 23'h100000,
		ST_SAVE  = 23'h200000,
		ST_FIN   = 23'h400000
	} state_t;

	typedef enum logic [1:0] {
		JOB_ELEM = 2'd0,
		JOB_ROW  = 2'd1,
		JOB_BANK = 2'd2,
		JOB_SCAN = 2'd3
	} job_t;

	state_t              state_q;
	job_t                job_q;
	logic                cmd_q;
	logic [LBL_W-1:0]    flow_q;
	logic [LBL_W-1:0]    elem_q;
	logic [31:0]         hk_q;
	logic [31:0]         hh_q;
	logic [REG_W-1:0]    reg_q;
	logic [CNT_W-1:0]    rank_q;
	logic [ROW_W-1:0]    row_q;
	logic                bank_q;
	logic [REG_W-1:0]    idx_q;
	logic                set_q;
	logic [SUM_W-1:0]    sum_o_q;
	logic [SUM_W-1:0]    sum_c_q;
	logic [REG_W:0]      zer_o_q;
	logic [REG_W:0]      zer_c_q;
	logic [EST_W-1:0]    n_q;
	logic [EST_W-1:0]    est_o_q;
	logic [EST_W-1:0]    est_c_q;
	logic [LOG_W-1:0]    t_q;
	logic [E_W-1:0]      e_q;
	logic [31:0]         y_q;
	logic [31:0]         frac_q;
	logic [4:0]          sq_cnt_q;
	logic                lin_q;
	logic [E_W-1:0]      dhi_q;
	logic [31:0]         lop_q;
	logic [ADDR_W-1:0]   clr_q;
	logic                out_valid_q;
	logic [31:0]         out_q;

	logic [MUL_W-1:0]    mul_a;
	logic [MUL_W-1:0]    mul_b;
	logic [2*MUL_W-1:0]  mul_p;
	logic [31:0]         p_lo;
	logic [31:0]         hres;
	logic [31:0]         seed;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [BANK_W-1:0]   ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [BANK_W-1:0]   ram_rdata;
	logic [CNT_W-1:0]    cur_v;
	logic [CNT_W-1:0]    own_v;
	logic [CNT_W-1:0]    comp_v;

	logic                div_start;
	logic                div_done;
	logic [DVD_W-1:0]    div_quo;
	logic [SUM_W-1:0]    sum_sel;
	logic [REG_W:0]      zer_sel;
	logic [DVD_W-1:0]    dividend;

	logic [EST_W+4:0]    n30;
	logic [E_W+31:0]     log_v;
	logic [E_W+31:0]     log_base;
	logic [E_W+31:0]     log_d;
	logic [32:0]         y2;
	logic [MQ_W-1:0]     mq;
	logic [EST_W-1:0]    lin_n;
	logic [EST_W-1:0]    big_n;
	logic [EST_W-1:0]    diff_v;
	logic [EST_W-17:0]   dq;
	logic [31:0]         res_v;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	// Tail of one MurmurHash3 block: rotate, times five, add.
	function automatic logic [31:0] mixh(input logic [31:0] x);
		logic [31:0] r;
		r = rotl(x, 13);
		return (r << 2) + r + MM_ADD;
	endfunction

	// HyperLogLog rank: leading zeros of the low hash bits plus one.
	function automatic logic [CNT_W-1:0] rank_of(input logic [QW-1:0] q);
		logic [CNT_W-1:0] r;
		r = CNT_W'(QW + 1);
		for (int i = 0; i < QW; i++) begin
			if (q[i]) begin
				r = CNT_W'(QW - i);
			end
		end
		return r;
	endfunction

	hss_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	hss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (sum_sel),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Bank one in the upper field, bank zero in the lower field.
	hss_ram #(
		.WIDTH (BANK_W),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign p_lo = mul_p[31:0];
	assign hres = p_lo ^ (p_lo >> 16);

	// Seed of the hash now running.
	always_comb begin
		case (job_q)
			JOB_ELEM: seed = ELEM_SEED;
			JOB_ROW:  seed = ROW_SEED;
			JOB_BANK: seed = 32'(reg_q);
			JOB_SCAN: seed = 32'(idx_q);
			default:  seed = ROW_SEED;
		endcase
	end

	// Logarithm difference for the linear and large ranges.
	always_comb begin
		log_v    = {e_q, frac_q};
		log_base = lin_q ? {E_W'(REG_W), 32'd0} : {E_W'(LOG_W), 32'd0};
		log_d    = log_base - log_v;
		y2       = mul_p[63:31];
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		case (state_q)
			ST_K1: begin
				mul_a = (job_q == JOB_ELEM) ? elem_q : flow_q;
				mul_b = MM_C1;
			end
			ST_K2: begin
				mul_a = rotl(p_lo, 15);
				mul_b = MM_C2;
			end
			ST_F1: begin
				mul_a = (hh_q ^ MM_LEN) ^ ((hh_q ^ MM_LEN) >> 16);
				mul_b = MM_C3;
			end
			ST_F2: begin
				mul_a = p_lo ^ (p_lo >> 13);
				mul_b = MM_C4;
			end
			ST_LSQ: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			ST_LM1: begin
				mul_a = log_d[31:0];
				mul_b = LN2_Q32;
			end
			ST_LM2: begin
				mul_a = MUL_W'(dhi_q);
				mul_b = LN2_Q32;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Register memory ports: clearing pass, update write-back, reads.
	always_comb begin
		cur_v     = bank_q ? ram_rdata[BANK_W-1:CNT_W] : ram_rdata[CNT_W-1:0];
		own_v     = cur_v;
		comp_v    = bank_q ? ram_rdata[CNT_W-1:0] : ram_rdata[BANK_W-1:CNT_W];
		ram_raddr = {row_q, (job_q == JOB_SCAN) ? idx_q : reg_q};
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = (state_q == ST_UPD) && (rank_q > cur_v);
			ram_waddr = {row_q, reg_q};
			ram_wdata = bank_q ? {rank_q, ram_rdata[CNT_W-1:0]}
			                   : {ram_rdata[BANK_W-1:CNT_W], rank_q};
		end
	end

	// Estimate arithmetic around the divider and the logarithm.
	always_comb begin
		sum_sel   = set_q ? sum_c_q : sum_o_q;
		zer_sel   = set_q ? zer_c_q : zer_o_q;
		dividend  = (DVD_W'(NUM_Q32) << 16) + DVD_W'(sum_sel >> 1);
		div_start = (state_q == ST_DIVS);
		n30       = {n_q, 5'd0} - (EST_W+5)'({n_q, 1'b0});
		mq        = MQ_W'(mul_p[MQ_W-1:0]) + MQ_W'(lop_q);
		lin_n     = EST_W'({mq, {REG_W{1'b0}}} >> 16);
		big_n     = EST_W'({mq, 16'd0});
		diff_v    = (est_o_q >= est_c_q) ? est_o_q - est_c_q : est_c_q - est_o_q;
		dq        = diff_v[EST_W-1:16];
		if (dq == '0) begin
			res_v = 32'd1;
		end else if (|dq[EST_W-17:32]) begin
			res_v = 32'hFFFFFFFF;
		end else begin
			res_v = dq[31:0];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The output register is loaded in the final state and emptied by a transfer.
			if (state_q == ST_FIN && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE:  if (in_valid) state_q <= ST_K1;
				ST_K1:    state_q <= ST_K2;
				ST_K2:    state_q <= ST_KS;
				ST_KS:    state_q <= ST_H1;
				ST_H1:    state_q <= ST_H2;
				ST_H2:    state_q <= ST_F1;
				ST_F1:    state_q <= ST_F2;
				ST_F2:    state_q <= ST_F3;
				ST_F3: begin
					case (job_q)
						JOB_ELEM: state_q <= ST_K1;
						JOB_ROW:  state_q <= ST_H1;
						JOB_BANK: state_q <= ST_UPD;
						JOB_SCAN: state_q <= ST_ACC;
						default:  state_q <= ST_IDLE;
					endcase
				end
				ST_UPD:   state_q <= ST_IDLE;
				ST_ACC:   state_q <= (idx_q == REG_W'(REGS - 1)) ? ST_DIVS : ST_H1;
				ST_DIVS:  state_q <= ST_DIVW;
				ST_DIVW:  if (div_done) state_q <= ST_CHK;
				ST_CHK: begin
					if (n_q <= LIN_LIMIT) begin
						state_q <= (zer_sel != '0) ? ST_LNORM : ST_SAVE;
					end else if (n30 > ((EST_W+5)'(1) << LOG_W)) begin
						state_q <= (n_q >= (EST_W'(1) << LOG_W)) ? ST_SAVE : ST_LNORM;
					end else begin
						state_q <= ST_SAVE;
					end
				end
				ST_LNORM: if (t_q[LOG_W-1]) state_q <= ST_LSQ;
				ST_LSQ:   state_q <= ST_LSQ2;
				ST_LSQ2:  state_q <= (sq_cnt_q == 5'd31) ? ST_LM1 : ST_LSQ;
				ST_LM1:   state_q <= ST_LM2;
				ST_LM2:   state_q <= ST_LM3;
				ST_LM3:   state_q <= ST_SAVE;
				ST_SAVE:  state_q <= set_q ? ST_FIN : ST_DIVS;
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd_q  <= cmd;
					flow_q <= flow_key;
					elem_q <= element_label;
					job_q  <= (cmd == CMD_QUERY) ? JOB_ROW : JOB_ELEM;
				end
			end
			ST_KS: hk_q <= p_lo;
			ST_H1: hh_q <= mixh(seed ^ hk_q);
			ST_H2: hh_q <= mixh(hh_q);
			ST_F3: begin
				case (job_q)
					JOB_ELEM: begin
						reg_q  <= hres[31 -: REG_W];
						rank_q <= rank_of(hres[QW-1:0]);
						job_q  <= JOB_ROW;
					end
					JOB_ROW: begin
						row_q <= hres[ROW_W-1:0];
						if (cmd_q == CMD_UPDATE) begin
							job_q <= JOB_BANK;
						end else begin
							job_q   <= JOB_SCAN;
							idx_q   <= '0;
							sum_o_q <= '0;
							sum_c_q <= '0;
							zer_o_q <= '0;
							zer_c_q <= '0;
						end
					end
					default: bank_q <= hres[0];
				endcase
			end
			ST_ACC: begin
				sum_o_q <= sum_o_q + SUM_W'(33'h1 << (6'd32 - {1'b0, own_v}));
				sum_c_q <= sum_c_q + SUM_W'(33'h1 << (6'd32 - {1'b0, comp_v}));
				zer_o_q <= zer_o_q + (REG_W+1)'(own_v == '0);
				zer_c_q <= zer_c_q + (REG_W+1)'(comp_v == '0);
				idx_q   <= idx_q + REG_W'(1);
				set_q   <= 1'b0;
			end
			ST_DIVW: if (div_done) n_q <= div_quo;
			ST_CHK: begin
				e_q <= E_W'(LOG_W - 1);
				if (n_q <= LIN_LIMIT) begin
					lin_q <= 1'b1;
					t_q   <= LOG_W'(zer_sel);
				end else begin
					lin_q <= 1'b0;
					t_q   <= LOG_W'((EST_W'(1) << LOG_W) - n_q);
					if (n_q >= (EST_W'(1) << LOG_W)) begin
						n_q <= MAX_Q16;
					end
				end
			end
			ST_LNORM: begin
				if (t_q[LOG_W-1]) begin
					y_q      <= t_q[LOG_W-1 -: 32];
					frac_q   <= '0;
					sq_cnt_q <= '0;
				end else begin
					t_q <= t_q << 1;
					e_q <= e_q - E_W'(1);
				end
			end
			ST_LSQ2: begin
				y_q      <= y2[32] ? y2[32:1] : y2[31:0];
				frac_q   <= {frac_q[30:0], y2[32]};
				sq_cnt_q <= sq_cnt_q + 5'd1;
			end
			ST_LM1: dhi_q <= log_d[E_W+31:32];
			ST_LM2: lop_q <= mul_p[63:32];
			ST_LM3: n_q <= lin_q ? lin_n : big_n;
			ST_SAVE: begin
				if (set_q) begin
					est_c_q <= n_q;
				end else begin
					est_o_q <= n_q;
					set_q   <= 1'b1;
				end
			end
			ST_FIN: if (!out_valid_q || out_ready) out_q <= res_v;
			default: begin
			end
		endcase
	end

	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = out_valid_q;
	assign spread_estimate = out_q;

	// A new result appears only out of the final state of a query.
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the final state");

	// The divider reports completion only while the sequencer waits for it.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIVW))
		else $error("divider finished while not awaited");

	// The memory is written only by the clearing pass or an update.
	a_ram_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_UPD))
		else $error("memory written outside clear or update");

	// The squaring loop keeps its mantissa normalized.
	a_log_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LSQ) |-> y_q[31])
		else $error("log mantissa lost its leading one");

endmodule

// File: hdl/hss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module hss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/hss_mul.sv
// Shared 32x32 multiplier with a registered 64-bit product.
// Depends on hss_pkg for the operand width.
module hss_mul import hss_pkg::*; (
	input  logic               clk,
	input  logic [MUL_W-1:0]   a,
	input  logic [MUL_W-1:0]   b,
	output logic [2*MUL_W-1:0] p
);

	// One product per cycle, ready in the cycle after the operands.
	always_ff @(posedge clk) begin
		p <= (2*MUL_W)'(a) * (2*MUL_W)'(b);
	end

endmodule

// File: hdl/hss_div.sv
// Restoring divider, one quotient bit per cycle, for the raw estimate.
// Depends on hss_pkg for the dividend and divisor widths.
module hss_div import hss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              ge;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	// Control: counts DVD_W steps while busy, then raises a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DCNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + DCNT_W'(1);
			end
		end
	end

	// Datapath: remaining dividend bits shift out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: tb/tb_rerouted_hll_spread_sketch_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the rerouted HyperLogLog spread sketch.
// Depends on hss_pkg and rerouted_hll_spread_sketch_top; predicts every spread estimate.
module tb_rerouted_hll_spread_sketch_top;
	import hss_pkg::*;

	typedef struct packed {
		logic        cmd;
		logic [31:0] flow;
		logic [31:0] elem;
	} sketch_item_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        cmd;
	logic [31:0] flow_key;
	logic [31:0] element_label;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] spread_estimate;

	rerouted_hll_spread_sketch_top i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .flow_key(flow_key), .element_label(element_label),
		.out_valid(out_valid), .out_ready(out_ready),
		.spread_estimate(spread_estimate)
	);

	// Predictor state: both register banks, indexed row*REGS+reg.
	logic [4:0] bank0_model [CELLS];
	logic [4:0] bank1_model [CELLS];

	sketch_item_t pending_items[$];
	logic [31:0]  expected_spreads[$];
	int           fail_count = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;

	function automatic logic [31:0] rotl(logic [31:0] x, int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] murmur_block(logic [31:0] h, logic [31:0] k);
		k = k * MM_C1;
		k = rotl(k, 15);
		k = k * MM_C2;
		h = h ^ k;
		h = rotl(h, 13);
		return h * 32'd5 + MM_ADD;
	endfunction

	function automatic logic [31:0] murmur8(logic [31:0] label, logic [31:0] seed);
		logic [31:0] h;
		h = murmur_block(seed, label);
		h = murmur_block(h, 32'd0);
		h = h ^ MM_LEN;
		h = h ^ (h >> 16);
		h = h * MM_C3;
		h = h ^ (h >> 13);
		h = h * MM_C4;
		h = h ^ (h >> 16);
		return h;
	endfunction

	function automatic logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
		return (a >> 32) * b + (((a & 64'hFFFFFFFF) * b) >> 32);
	endfunction

	function automatic logic [63:0] log2_q32(logic [63:0] x);
		int unsigned e;
		logic [63:0] y;
		logic [63:0] frac;
		e = 0;
		frac = 0;
		if (x == 0) return 0;
		while ((x >> e) > 1) e++;
		y = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
		for (int i = 0; i < 32; i++) begin
			y = (y * y) >> 31;
			frac = frac << 1;
			if (y >= (64'd1 << 32)) begin
				y = y >> 1;
				frac = frac | 1;
			end
		end
		return (64'(e) << 32) | frac;
	endfunction

	// Cardinality of one register set in Q16, with both range corrections.
	function automatic logic [63:0] cardinality_q16(logic [4:0] r [REGS]);
		logic [63:0] sum;
		logic [63:0] zeros;
		logic [63:0] n;
		logic [63:0] d;
		sum = 0;
		zeros = 0;
		for (int i = 0; i < REGS; i++) begin
			sum += 64'd1 << (32 - r[i]);
			if (r[i] == 0) zeros++;
		end
		n = ((NUM_Q32 << 16) + sum / 2) / sum;
		if (n <= (64'(5 * REGS) << 15)) begin
			if (zeros != 0) begin
				d = log2_q32(REGS) - log2_q32(zeros);
				n = (64'(REGS) * mul_q32(d, LN2_Q32)) >> 16;
			end
		end else if (n * 30 > (64'd1 << 48)) begin
			if (n >= (64'd1 << 48))
				n = 64'hFFFFFFFF << 16;
			else begin
				d = (64'd48 << 32) - log2_q32((64'd1 << 48) - n);
				n = mul_q32(d, LN2_Q32) << 16;
			end
		end
		return n;
	endfunction

	// Applies one item to the predictor; queues an expected spread on a query.
	function automatic void predict_sketch(sketch_item_t it);
		logic [31:0] base;
		logic [31:0] h;
		logic [31:0] q;
		logic [31:0] reg_idx;
		int unsigned len;
		int unsigned rank;
		logic [4:0] own [REGS];
		logic [4:0] comp [REGS];
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] d;
		base = (murmur8(it.flow, ROW_SEED) % ROWS) * REGS;
		if (it.cmd == CMD_UPDATE) begin
			h = murmur8(it.elem, ELEM_SEED);
			reg_idx = h >> QW;
			q = h & ((32'd1 << QW) - 1);
			len = 0;
			while (q != 0) begin
				len++;
				q = q >> 1;
			end
			rank = QW - len + 1;
			if (murmur8(it.flow, reg_idx) & 1) begin
				if (rank > bank1_model[base + reg_idx]) bank1_model[base + reg_idx] = 5'(rank);
			end else begin
				if (rank > bank0_model[base + reg_idx]) bank0_model[base + reg_idx] = 5'(rank);
			end
		end else begin
			for (int i = 0; i < REGS; i++) begin
				if ((murmur8(it.flow, i) & 1) == 0) begin
					own[i] = bank0_model[base + i];
					comp[i] = bank1_model[base + i];
				end else begin
					own[i] = bank1_model[base + i];
					comp[i] = bank0_model[base + i];
				end
			end
			a = cardinality_q16(own);
			b = cardinality_q16(comp);
			d = (a > b ? a - b : b - a) >> 16;
			if (d < 1) d = 1;
			if (d > 64'hFFFFFFFF) d = 64'hFFFFFFFF;
			expected_spreads.push_back(d[31:0]);
		end
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Driver: presents queued items, idling at random between transfers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			cmd <= CMD_UPDATE;
			flow_key <= 0;
			element_label <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) predict_sketch({cmd, flow_key, element_label});
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				sketch_item_t it;
				it = pending_items.pop_front();
				in_valid <= 1;
				cmd <= it.cmd;
				flow_key <= it.flow;
				element_label <= it.elem;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// Monitor: checks each result transfer and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_spreads.size() == 0) begin
					$error("unexpected spread_estimate %0d", spread_estimate);
					fail_count++;
				end else begin
					logic [31:0] exp_val;
					exp_val = expected_spreads.pop_front();
					if (exp_val !== spread_estimate) begin
						$error("spread_estimate expected %0d actual %0d", exp_val,
							spread_estimate);
						fail_count++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic add_item(logic c, logic [31:0] f, logic [31:0] e);
		pending_items.push_back('{cmd: c, flow: f, elem: e});
	endtask

	// Waits for the driver to drain its queue and for every result to arrive.
	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_spreads.size() > 0)
			@(posedge clk);
	endtask

	// Builds a random mix of update batches to four flows and queries of them, with noise.
	task automatic add_random_phase(int n_items);
		logic [31:0] flows [4];
		int unsigned k;
		int unsigned sz;
		for (int i = 0; i < 4; i++) flows[i] = $urandom();
		k = 0;
		while (k < n_items) begin
			case ($urandom_range(9))
				0: begin
					add_item(CMD_QUERY, $urandom(), $urandom());
					k++;
				end
				1, 2: begin
					add_item(CMD_QUERY, flows[$urandom_range(3)], $urandom());
					k++;
				end
				default: begin
					sz = $urandom_range(1, 12);
					for (int j = 0; j < sz; j++)
						add_item(CMD_UPDATE, flows[$urandom_range(3)], $urandom());
					k += sz;
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 0;
		for (int i = 0; i < CELLS; i++) begin
			bank0_model[i] = 0;
			bank1_model[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1;

		// Directed: empty sketch, extreme labels, saturating ranks, large spread.
		add_item(CMD_QUERY, 32'h0, 32'h0);
		add_item(CMD_QUERY, 32'hFFFFFFFF, 32'hFFFFFFFF);
		add_item(CMD_UPDATE, 32'h0, 32'h0);
		add_item(CMD_UPDATE, 32'hFFFFFFFF, 32'hFFFFFFFF);
		add_item(CMD_UPDATE, 32'h0, 32'hFFFFFFFF);
		add_item(CMD_QUERY, 32'h0, 32'hFFFFFFFF);
		add_item(CMD_QUERY, 32'hFFFFFFFF, 32'h0);
		for (int i = 0; i < 14; i++) add_item(CMD_UPDATE, 32'h5A5A5A5A, 32'(i) << 20);
		add_item(CMD_QUERY, 32'h5A5A5A5A, 32'h0);
		add_item(CMD_QUERY, 32'h80000000, 32'h1);

		// Random phases under three idle profiles.
		send_idle_pct = 19;
		recv_idle_pct = 45;
		add_random_phase(530);
		drain();
		send_idle_pct = 45;
		recv_idle_pct = 19;
		add_random_phase(530);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// A heavy flow of 150 updates, followed by a query of that flow.
		for (int i = 0; i < 150; i++) add_item(CMD_UPDATE, 32'h00C0FFEE, $urandom());
		add_item(CMD_QUERY, 32'h00C0FFEE, 32'h0);
		add_random_phase(400);
		drain();
		repeat (700) @(posedge clk);
		if (fail_count == 0 && expected_spreads.size() == 0)
			$display("tb_rerouted_hll_spread_sketch_top passed");
		else
			$display("tb_rerouted_hll_spread_sketch_top failed");
		$finish;
	end

	// Watchdog: clearing pass plus ~1700 items at worst-case query latency, with margin.
	initial begin
		#50ms;
		$display("tb_rerouted_hll_spread_sketch_top failed");
		$finish;
	end

endmodule
